### design/tbd_pkg.sv
// Package for the triangle barycentric depth block: field widths, status codes,
// the metadata record that travels down the pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tbd_pkg;

   // input field widths
   localparam int LON_W   = 29;
   localparam int LAT_W   = 28;
   localparam int DEPTH_W = 16;

   // coordinate differences and cross products
   localparam int DX_W   = LON_W + 1;
   localparam int DY_W   = LAT_W + 1;
   localparam int PROD_W = DX_W + DY_W;
   localparam int NUM_W  = PROD_W + 1;

   // result field widths
   localparam int WT_W    = 18;
   localparam int DOUT_W  = 17;
   localparam int STAT_W  = 2;

   // quotient bits kept by the divider; anything at or above 2^Q_BITS saturates
   localparam int Q_BITS = WT_W + 1;

   // weighted depth sum: three 18x17 products
   localparam int DPROD_W = WT_W + DEPTH_W + 1;
   localparam int SUM_W   = DPROD_W + 2;

   // depth saturation magnitudes
   localparam int D_POS_MAG = (1 << (DOUT_W - 1)) - 1;
   localparam int D_NEG_MAG = (1 << (DOUT_W - 1));

   localparam int WEIGHT_FRAC_BITS_DEF = 16;

   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 2'd0,
      ST_DEGEN   = 2'd1,
      ST_NOMESH  = 2'd2
   } status_type;

   // per-item side information carried through every stage
   typedef struct packed {
      logic [DEPTH_W-1:0] depth_a;
      logic [DEPTH_W-1:0] depth_b;
      logic [DEPTH_W-1:0] depth_c;
      logic               in_mesh;
      status_type         status;
      logic [2:0]         neg;
      logic [2:0]         ovf;
   } meta_type;

endpackage

`default_nettype wire

### design/triangle_barycentric_depth.sv
// Top level of the triangle barycentric depth block: a fully pipelined
// cross-product, restoring-division and weighted-sum datapath. Uses tbd_pkg.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------------
//  req     | in  | req_tvalid/req_tready  | tdata: 8 coordinates, 3 depths
//          |     |                        | tuser: in_mesh
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata: 3 weights, depth_out
//          |     |                        | tuser: status
//
//  One request enters per cycle unless stalled; the pipeline holds 9 + Q_BITS
//  stages (28 with package widths), the 19 one-bit divider stages setting depth.
//  Each stage holds its valid bit and stalls only when it is full and the stage
//  after it cannot take its content, so bubbles close up under back-pressure.
//  Synchronous reset clears the valid bits; datapath registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module triangle_barycentric_depth #(
   parameter int WEIGHT_FRAC_BITS = tbd_pkg::WEIGHT_FRAC_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // ref_lon[28:0] ref_lat[56:29] first_lon[85:57] first_lat[113:86]
   // second_lon[142:114] second_lat[170:143] third_lon[199:171]
   // third_lat[227:200] depth_a[243:228] depth_b[259:244] depth_c[275:260]
   input  wire logic [279:0] req_tdata,
   // in_mesh[0]
   input  wire logic [0:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // weight_a[17:0] weight_b[35:18] weight_c[53:36] depth_out[70:54]
   output logic [71:0]       rsp_tdata,
   // status[1:0]
   output logic [1:0]        rsp_tuser
);

   import tbd_pkg::*;

   localparam int FRAC = WEIGHT_FRAC_BITS;
   // working width of the divider remainder
   localparam int WW   = NUM_W + FRAC + 1 + Q_BITS;

   // stage numbers
   localparam int S_A  = 0;
   localparam int S_B  = 1;
   localparam int S_C  = 2;
   localparam int S_D  = 3;
   localparam int S_E  = 4;
   localparam int S_R  = S_E + Q_BITS + 1;
   localparam int S_M  = S_R + 1;
   localparam int S_S  = S_R + 2;
   localparam int S_O  = S_R + 3;
   localparam int NS   = S_O + 1;

   localparam logic signed [WT_W-1:0] W_MAX = {1'b0, {(WT_W-1){1'b1}}};
   localparam logic signed [WT_W-1:0] W_MIN = {1'b1, {(WT_W-1){1'b0}}};
   localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC - 1);

   // ---------------------------------------------------------------------
   // stage control: valid bits and per-stage enables
   logic     valid_ff [NS];
   logic     en       [NS];
   meta_type meta_ff  [NS];
   meta_type meta_in  [NS];

   always_comb begin
      en[NS-1] = !valid_ff[NS-1] || rsp_tready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_tready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) valid_ff[k] <= 1'b0;
      end else begin
         if (en[0]) valid_ff[0] <= req_tvalid;
         for (int k = 1; k < NS; k++) begin
            if (en[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // unpack request
   logic signed [LON_W-1:0] xr, x1, x2, x3;
   logic signed [LAT_W-1:0] yr, y1, y2, y3;

   assign xr = req_tdata[28:0];
   assign yr = req_tdata[56:29];
   assign x1 = req_tdata[85:57];
   assign y1 = req_tdata[113:86];
   assign x2 = req_tdata[142:114];
   assign y2 = req_tdata[170:143];
   assign x3 = req_tdata[199:171];
   assign y3 = req_tdata[227:200];

   // ---------------------------------------------------------------------
   // stage A: coordinate differences
   logic signed [DX_W-1:0] a_dx21_ff, a_dx31_ff, a_dx32_ff, a_dxr1_ff, a_dxr3_ff;
   logic signed [DY_W-1:0] a_dy21_ff, a_dy31_ff, a_dy32_ff, a_dyr1_ff, a_dyr3_ff;

   always_ff @(posedge clock) begin
      if (en[S_A]) begin
         a_dx21_ff <= DX_W'(x2) - DX_W'(x1);
         a_dx31_ff <= DX_W'(x3) - DX_W'(x1);
         a_dx32_ff <= DX_W'(x3) - DX_W'(x2);
         a_dxr1_ff <= DX_W'(xr) - DX_W'(x1);
         a_dxr3_ff <= DX_W'(xr) - DX_W'(x3);
         a_dy21_ff <= DY_W'(y2) - DY_W'(y1);
         a_dy31_ff <= DY_W'(y3) - DY_W'(y1);
         a_dy32_ff <= DY_W'(y3) - DY_W'(y2);
         a_dyr1_ff <= DY_W'(yr) - DY_W'(y1);
         a_dyr3_ff <= DY_W'(yr) - DY_W'(y3);
      end
   end

   // ---------------------------------------------------------------------
   // stage B: cross products, one multiplier each
   logic signed [PROD_W-1:0] b_pd1_ff, b_pd2_ff, b_p11_ff, b_p12_ff;
   logic signed [PROD_W-1:0] b_p21_ff, b_p22_ff, b_p31_ff, b_p32_ff;

   always_ff @(posedge clock) begin
      if (en[S_B]) begin
         b_pd1_ff <= PROD_W'(a_dy31_ff) * PROD_W'(a_dx21_ff);
         b_pd2_ff <= PROD_W'(a_dx31_ff) * PROD_W'(a_dy21_ff);
         b_p11_ff <= PROD_W'(a_dyr3_ff) * PROD_W'(a_dx32_ff);
         b_p12_ff <= PROD_W'(a_dxr3_ff) * PROD_W'(a_dy32_ff);
         b_p21_ff <= PROD_W'(a_dxr1_ff) * PROD_W'(a_dy31_ff);
         b_p22_ff <= PROD_W'(a_dyr1_ff) * PROD_W'(a_dx31_ff);
         b_p31_ff <= PROD_W'(a_dyr1_ff) * PROD_W'(a_dx21_ff);
         b_p32_ff <= PROD_W'(a_dxr1_ff) * PROD_W'(a_dy21_ff);
      end
   end

   // ---------------------------------------------------------------------
   // stage C: denominator and numerators
   logic signed [NUM_W-1:0] c_den_ff;
   logic signed [NUM_W-1:0] c_num_ff [3];

   always_ff @(posedge clock) begin
      if (en[S_C]) begin
         c_den_ff    <= NUM_W'(b_pd1_ff) - NUM_W'(b_pd2_ff);
         c_num_ff[0] <= NUM_W'(b_p11_ff) - NUM_W'(b_p12_ff);
         c_num_ff[1] <= NUM_W'(b_p21_ff) - NUM_W'(b_p22_ff);
         c_num_ff[2] <= NUM_W'(b_p31_ff) - NUM_W'(b_p32_ff);
      end
   end

   // ---------------------------------------------------------------------
   // stage D: magnitudes (sign and status go in the metadata)
   logic [NUM_W-1:0] d_an_ff [3];
   logic [NUM_W-1:0] d_ad_ff;

   always_ff @(posedge clock) begin
      if (en[S_D]) begin
         d_ad_ff <= (c_den_ff < 0) ? NUM_W'(-c_den_ff) : NUM_W'(c_den_ff);
         for (int i = 0; i < 3; i++) begin
            d_an_ff[i] <= (c_num_ff[i] < 0) ? NUM_W'(-c_num_ff[i]) : NUM_W'(c_num_ff[i]);
         end
      end
   end

   // ---------------------------------------------------------------------
   // stage E: scaled dividend and quotient overflow test
   logic [2:0]       e_ovf;
   logic [WW-1:0]    dv_rem_ff [Q_BITS+1][3];
   logic [Q_BITS-1:0] dv_q_ff  [Q_BITS+1][3];
   logic [NUM_W-1:0] dv_ad_ff  [Q_BITS+1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e_ovf[i] = ((WW'(d_an_ff[i]) << (FRAC + 1)) >= (WW'(d_ad_ff) << Q_BITS));
      end
   end

   always_ff @(posedge clock) begin
      if (en[S_E]) begin
         dv_ad_ff[0] <= d_ad_ff;
         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[0][i] <= WW'(d_an_ff[i]) << (FRAC + 1);
            dv_q_ff[0][i]   <= '0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // metadata: depths enter here, then copies down the line
   always_comb begin
      meta_in[0]          = '0;
      meta_in[0].depth_a  = req_tdata[243:228];
      meta_in[0].depth_b  = req_tdata[259:244];
      meta_in[0].depth_c  = req_tdata[275:260];
      meta_in[0].in_mesh  = req_tuser[0];
      meta_in[0].status   = ST_OK;
      for (int k = 1; k < NS; k++) meta_in[k] = meta_ff[k-1];
      // status settles once the denominator is known
      priority if (!meta_ff[S_D-1].in_mesh) meta_in[S_D].status = ST_NOMESH;
      else if (c_den_ff == '0)              meta_in[S_D].status = ST_DEGEN;
      else                                  meta_in[S_D].status = ST_OK;
      meta_in[S_D].neg = {(c_num_ff[2] < 0) != (c_den_ff < 0),
                          (c_num_ff[1] < 0) != (c_den_ff < 0),
                          (c_num_ff[0] < 0) != (c_den_ff < 0)};
      meta_in[S_E].ovf = e_ovf;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (en[k]) meta_ff[k] <= meta_in[k];
      end
   end

   // ---------------------------------------------------------------------
   // divider: one quotient bit per stage, most significant first
   for (genvar j = 0; j < Q_BITS; j++) begin : g_div
      localparam int KB = Q_BITS - 1 - j;
      logic [WW-1:0]     dvs;
      logic [WW-1:0]     rem_in [3];
      logic [Q_BITS-1:0] q_in   [3];

      always_comb begin
         dvs = WW'(dv_ad_ff[j]) << KB;
         for (int i = 0; i < 3; i++) begin
            rem_in[i] = dv_rem_ff[j][i];
            q_in[i]   = dv_q_ff[j][i];
            if (dv_rem_ff[j][i] >= dvs) begin
               rem_in[i]   = dv_rem_ff[j][i] - dvs;
               q_in[i][KB] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[S_E+1+j]) begin
            dv_ad_ff[j+1] <= dv_ad_ff[j];
            for (int i = 0; i < 3; i++) begin
               dv_rem_ff[j+1][i] <= rem_in[i];
               dv_q_ff[j+1][i]   <= q_in[i];
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // stage R: round half up on magnitude, apply sign, saturate, mask
   logic signed [WT_W-1:0] r_w_ff [3];
   logic signed [WT_W-1:0] r_w_in [3];
   logic [Q_BITS:0]        r_qp1  [3];
   logic [Q_BITS-1:0]      r_mag  [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         r_qp1[i] = (Q_BITS+1)'(dv_q_ff[Q_BITS][i]) + (Q_BITS+1)'(1);
         r_mag[i] = r_qp1[i][Q_BITS:1];
         if (meta_ff[S_R-1].ovf[i] || r_mag[i] >= Q_BITS'(1 << (WT_W - 1))) begin
            r_w_in[i] = meta_ff[S_R-1].neg[i] ? W_MIN : W_MAX;
         end else if (meta_ff[S_R-1].neg[i]) begin
            r_w_in[i] = -WT_W'(r_mag[i]);
         end else begin
            r_w_in[i] = WT_W'(r_mag[i]);
         end
         if (meta_ff[S_R-1].status != ST_OK) r_w_in[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[S_R]) begin
         for (int i = 0; i < 3; i++) r_w_ff[i] <= r_w_in[i];
      end
   end

   // ---------------------------------------------------------------------
   // stage M: weight times depth
   logic signed [WT_W-1:0]    m_w_ff [3];
   logic signed [DPROD_W-1:0] m_p_ff [3];

   always_ff @(posedge clock) begin
      if (en[S_M]) begin
         m_p_ff[0] <= DPROD_W'(r_w_ff[0]) *
                      DPROD_W'($signed({1'b0, meta_ff[S_M-1].depth_a}));
         m_p_ff[1] <= DPROD_W'(r_w_ff[1]) *
                      DPROD_W'($signed({1'b0, meta_ff[S_M-1].depth_b}));
         m_p_ff[2] <= DPROD_W'(r_w_ff[2]) *
                      DPROD_W'($signed({1'b0, meta_ff[S_M-1].depth_c}));
         for (int i = 0; i < 3; i++) m_w_ff[i] <= r_w_ff[i];
      end
   end

   // ---------------------------------------------------------------------
   // stage S: weighted sum
   logic signed [WT_W-1:0]  s_w_ff [3];
   logic signed [SUM_W-1:0] s_sum_ff;

   always_ff @(posedge clock) begin
      if (en[S_S]) begin
         s_sum_ff <= SUM_W'(m_p_ff[0]) + SUM_W'(m_p_ff[1]) + SUM_W'(m_p_ff[2]);
         for (int i = 0; i < 3; i++) s_w_ff[i] <= m_w_ff[i];
      end
   end

   // ---------------------------------------------------------------------
   // stage O: round the depth half away from zero, saturate, output register
   logic signed [WT_W-1:0]   o_w_ff [3];
   logic signed [DOUT_W-1:0] o_d_ff;
   logic signed [DOUT_W-1:0] o_d_in;
   logic [SUM_W-1:0]         o_abs;
   logic [SUM_W-1:0]         o_rnd;
   logic [SUM_W-1:0]         o_mr;
   logic                     o_neg;

   always_comb begin
      o_neg = (s_sum_ff < 0);
      o_abs = o_neg ? SUM_W'(-s_sum_ff) : SUM_W'(s_sum_ff);
      o_rnd = o_abs + HALF;
      o_mr  = o_rnd >> FRAC;
      if (o_neg) begin
         o_d_in = (o_mr >= SUM_W'(D_NEG_MAG)) ? DOUT_W'(-D_NEG_MAG) : -DOUT_W'(o_mr);
      end else begin
         o_d_in = (o_mr >= SUM_W'(D_POS_MAG)) ? DOUT_W'(D_POS_MAG) : DOUT_W'(o_mr);
      end
   end

   always_ff @(posedge clock) begin
      if (en[S_O]) begin
         o_d_ff <= o_d_in;
         for (int i = 0; i < 3; i++) o_w_ff[i] <= s_w_ff[i];
      end
   end

   assign rsp_tvalid = valid_ff[S_O];
   assign rsp_tdata  = {1'b0, o_d_ff, o_w_ff[2], o_w_ff[1], o_w_ff[0]};
   assign rsp_tuser  = meta_ff[S_O].status;

   // ---------------------------------------------------------------------
   // assertions

   // a degenerate or off-mesh result carries all-zero weights and depth
   a_zero_on_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> rsp_tdata == '0)
      else $error("nonzero payload with fault status");

   // request side backs up only when the first and last stages are full and the output is stalled
   a_full_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> valid_ff[S_A] && valid_ff[S_O] && !rsp_tready)
      else $error("request stalled with room in the pipeline");

   // no result directly after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // a result carries one of the three defined status codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ST_OK) || (rsp_tuser == ST_DEGEN) ||
                     (rsp_tuser == ST_NOMESH))
      else $error("status out of range");

endmodule

`default_nettype wire
